/* sv/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256 package
// constants, types and round functions used by the stream hasher
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int HASH_WORDS  = 8;
    localparam int SCHED_WORDS = 16;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_POS  = 7'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

/* sv/sha256_ram.sv */
// ----------------------------------------------------------------------------
// sha256 ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* sv/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256 stream hasher
// flow: a plain byte is taken while idle; a byte that fills the block holds off the
// next request while the block is loaded into ram, run through the rounds and added
// end of message: pad bytes to the block end and one compression, or a second pad block
// and compression when the length does not fit, then the eight digest words go out
// reset: synchronous active low; hash, fill count and bit length go to initial values
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_number,
    output logic             o_last_word
);
    import sha256_pkg::*;

    t_state r_state, n_state;
    logic [31:0] r_h [HASH_WORDS];
    logic [31:0] r_v [HASH_WORDS];
    logic [31:0] r_blk [SCHED_WORDS];   // block words, loaded into ram
    logic [6:0]  r_fill, n_fill;
    logic [63:0] r_len, n_len, r_len_snap, len_sum;
    logic        r_final;               // message is being finalized
    logic [6:0]  r_t;                   // round counter / load index
    logic        r_ph;                  // 0x80 still to be written
    logic        r_late;                // 0x80 went past byte 55, length in next block
    logic [2:0]  r_oidx;

    // schedule ram: w[t] rolled in 16 entries; taps read over sub-steps
    logic        ram_we;
    logic [3:0]  ram_addr;
    logic [31:0] ram_wdata, ram_rdata;
    sha256_ram #(.WIDTH(32), .DEPTH(SCHED_WORDS)) u_sched (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );
    // tap registers for w[t-16], w[t-15], w[t-7]; w[t-2] comes straight from the ram
    logic [31:0] r_tap [3];
    logic [2:0]  r_sub;

    logic [7:0] pad_byte;
    logic       in_acc;
    assign o_ready = (r_state == ST_IDLE);
    assign in_acc  = i_valid && o_ready;

    // padding byte for current fill position
    always_comb begin
        if (r_ph) begin
            pad_byte = PAD_BYTE;
        end else if (r_fill >= LEN_POS && !r_late) begin
            pad_byte = r_len_snap[{3'(7'd63 - r_fill), 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    logic [31:0] w_new, t1, t2, s0, s1;
    always_comb begin
        s0 = rotr(r_tap[1], 7) ^ rotr(r_tap[1], 18) ^ (r_tap[1] >> 3);
        s1 = rotr(ram_rdata, 17) ^ rotr(ram_rdata, 19) ^ (ram_rdata >> 10);
        w_new = (r_t < 7'd16) ? r_tap[0] : r_tap[0] + s0 + r_tap[2] + s1;
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_t[5:0]) + w_new;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // ram port sequencing
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_t[3:0];
        ram_wdata = r_blk[r_t[3:0]];
        if (r_state == ST_LOAD) begin
            ram_we = 1'b1;
        end else if (r_state == ST_ROUND) begin
            case (r_sub)
                3'd0: ram_addr = r_t[3:0];
                3'd1: ram_addr = 4'(r_t[3:0] - 4'd15);
                3'd2: ram_addr = 4'(r_t[3:0] - 4'd7);
                3'd3: ram_addr = 4'(r_t[3:0] - 4'd2);
                default: begin
                    ram_addr  = r_t[3:0];
                    ram_we    = 1'b1;
                    ram_wdata = w_new;
                end
            endcase
        end
    end

    logic full_blk;
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_len    = r_len;
        full_blk = 1'b0;
        len_sum  = r_len + (i_byte_present ? 64'd8 : 64'd0);
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        n_fill = r_fill + 7'd1;
                        full_blk = (r_fill == 7'd63);
                    end
                    n_len = i_end_of_message ? 64'd0 : len_sum;
                    if (full_blk) begin
                        n_fill  = 7'd0;
                        n_state = ST_LOAD;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_fill = r_fill + 7'd1;
                if (r_fill == 7'd63) begin
                    n_fill  = 7'd0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:  if (r_t == 7'd15) n_state = ST_ROUND;
            ST_ROUND: if (r_t == 7'd63 && r_sub == 3'd4) n_state = ST_ADD;
            ST_ADD: begin
                if (!r_final) n_state = ST_IDLE;
                else if (r_len_done) n_state = ST_OUT;
                else n_state = ST_PAD;
            end
            ST_OUT: if (i_ready && r_oidx == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // final pass ends when the block that held the length was compressed
    logic r_len_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= 7'd0;
            r_len   <= 64'd0;
            r_final <= 1'b0;
            r_len_done <= 1'b0;
            r_late  <= 1'b0;
            r_t     <= 7'd0;
            r_sub   <= 3'd0;
            r_ph    <= 1'b0;
            r_oidx  <= 3'd0;
            for (int i = 0; i < HASH_WORDS; i++) r_h[i] <= init_hash(3'(i));
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_len   <= n_len;
            case (r_state)
                ST_IDLE: begin
                    r_t <= 7'd0;
                    if (in_acc && i_byte_present) begin
                        r_blk[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_data_byte;
                    end
                    if (in_acc && i_end_of_message) begin
                        r_final    <= 1'b1;
                        r_len_done <= 1'b0;
                        r_late     <= 1'b0;
                        r_len_snap <= len_sum;
                    end
                    r_ph <= in_acc && i_end_of_message;  // padding pending
                end
                ST_PAD: begin
                    // first pad byte is 0x80, then zeros, then length
                    r_blk[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= pad_byte;
                    r_ph <= 1'b0;
                    if (r_ph && r_fill >= LEN_POS) r_late <= 1'b1;
                    if (r_fill == 7'd63 && !r_ph && !r_late) r_len_done <= 1'b1;
                    r_t <= 7'd0;
                end
                ST_LOAD: begin
                    r_t <= (r_t == 7'd15) ? 7'd0 : r_t + 7'd1;
                    r_sub <= 3'd0;
                    for (int i = 0; i < HASH_WORDS; i++) r_v[i] <= r_h[i];
                end
                ST_ROUND: begin
                    if (r_sub inside {3'd1, 3'd2, 3'd3}) r_tap[2'(r_sub - 3'd1)] <= ram_rdata;
                    if (r_sub == 3'd4) begin
                        r_sub <= 3'd0;
                        r_t   <= r_t + 7'd1;
                        r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                        r_v[4] <= r_v[3] + t1;
                        r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                        r_v[0] <= t1 + t2;
                    end else if (r_t < 7'd16 && r_sub == 3'd1) begin
                        r_sub <= 3'd4;  // no schedule taps in the first 16 rounds
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < HASH_WORDS; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= 3'd0;
                    r_late <= 1'b0;
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < HASH_WORDS; i++)
                                r_h[i] <= init_hash(3'(i));
                            r_final    <= 1'b0;
                            r_len_done <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_number = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);
endmodule
`default_nettype wire

/* sv/sha256_checker.sv */
// ----------------------------------------------------------------------------
// sha256 checker
// port-level properties of the hasher, bound into the hasher module
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_word_number,
    input wire logic        o_last_word
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("request taken while digest out");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_number == 3'd7))) else $error("last flag");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_word) |=> (o_valid &&
        o_word_number == $past(o_word_number) + 3'd1)) else $error("word order");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_word_number)) else $error("word moved");
endmodule

bind sha256_stream_hasher sha256_checker u_chk (.*);
`default_nettype wire

/* test/sha256_stream_hasher_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256 stream hasher testbench
// feeds byte requests with random content and idling, predicts the digest
// words with a behavioral sha-256 and compares every output word in order
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_last_word;

    sha256_stream_hasher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_byte_present(i_byte_present),
        .i_end_of_message(i_end_of_message),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_digest_word(o_digest_word), .o_word_number(o_word_number),
        .o_last_word(o_last_word)
    );

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  num;
        logic        last;
    } digest_t;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic       typed;       // row has a typed-in digest word 0
        logic [31:0] word0;
    } row_t;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] msg_bits;

    digest_t     digest_q [$];
    int          n_items, n_words, n_msgs, n_err;
    int          send_idle_pct, recv_stall_pct;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, t1, t2, a, b;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                a = w[(t-15) & 15];
                b = w[(t-2) & 15];
                wt = w[t & 15] + (ror(a, 7) ^ ror(a, 18) ^ (a >> 3)) + w[(t-7) & 15]
                     + (ror(b, 17) ^ ror(b, 19) ^ (b >> 10));
                w[t & 15] = wt;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + wt;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic add_byte(input logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 64) begin
            compress_block();
            fill = 0;
        end
    endtask

    task automatic predict_hash_request(input logic [7:0] d, input logic p, input logic e);
        logic [63:0] len;
        digest_t     dg;
        if (p) begin
            add_byte(d);
            msg_bits += 64'd8;
        end
        if (e) begin
            len = msg_bits;
            add_byte(8'h80);
            while (fill != 56) add_byte(8'h00);
            for (int i = 0; i < 8; i++) add_byte(len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                dg.word = hash_state[i];
                dg.num  = i[2:0];
                dg.last = (i == 7);
                digest_q = {digest_q, dg};
                hash_state[i] = H0[i];
            end
            fill = 0;
            msg_bits = '0;
            n_msgs++;
        end
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_request(input logic [7:0] d, input logic p, input logic e);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= d;
        i_byte_present   <= p;
        i_end_of_message <= e;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_hash_request(d, p, e);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (digest_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver
    always @(negedge i_clk) begin
        if (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct)
            i_ready <= 1'b0;
        else
            i_ready <= 1'b1;
    end

    // output checker
    always @(posedge i_clk) begin
        digest_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_digest_word, o_word_number, o_last_word};
            n_words++;
            if (digest_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected digest word %h", o_digest_word);
            end else begin
                want = digest_q.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp word %h num %0d last %b, got %h %0d %b",
                                 want.word, want.num, want.last,
                                 got.word, got.num, got.last);
                end
            end
        end
    end

    row_t rows [10];
    logic [31:0] got0;

    // word 0 of the known digests is checked again against the typed value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready && o_word_number == 3'd0) got0 = o_digest_word;
    end

    initial begin
        int phase, len, cnt;
        logic [7:0] b;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_byte_present = 1'b0;
        i_end_of_message = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_items = 0; n_words = 0; n_msgs = 0; n_err = 0;
        fill = 0; msg_bits = '0;
        for (int i = 0; i < 8; i++) hash_state[i] = H0[i];
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty message, "abc", idle items, all ones/zeros bytes
        rows = '{
            '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
            '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
            '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
            '{8'h00, 1'b0, 1'b1, 1'b0, 32'h0},
            '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
            '{8'h5a, 1'b0, 1'b1, 1'b0, 32'h0}
        };
        foreach (rows[r]) begin
            send_request(rows[r].data, rows[r].present, rows[r].eom);
            if (rows[r].typed) begin
                wait_drained();
                @(negedge i_clk);
                if (got0 !== rows[r].word0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("known digest: exp %h got %h", rows[r].word0, got0);
                end
            end
        end

        // random messages over the idling phases, short or near a block boundary
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            cnt = 0;
            while (cnt < 75) begin
                case ($urandom_range(5, 0))
                    0: len = $urandom_range(64, 54);
                    1: len = $urandom_range(128, 118);
                    default: len = $urandom_range(20, 0);
                endcase
                for (int i = 0; i < len; i++) begin
                    b = 8'($urandom);
                    if ($urandom_range(9, 0) == 0)
                        send_request(b, 1'b0, 1'b0);   // empty item
                    else
                        send_request(b, 1'b1, (i == len - 1) ? 1'b1 : 1'b0);
                    cnt++;
                end
                if (len == 0) begin
                    send_request(8'($urandom), 1'b0, 1'b1);
                    cnt++;
                end
                if ($urandom_range(7, 0) == 0) wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        repeat (300) @(negedge i_clk);
        $display("%0d requests, %0d messages, %0d digest words checked over four idling phases",
                 n_items, n_msgs, n_words);
        if (n_err == 0 && digest_q.size() == 0)
            $display("RESULT: OK");
        else begin
            $display("%0d mismatches, %0d words missing", n_err, digest_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
